/* hw/rtl/pulse_peak_pedestal_extractor_assert.svh */
// Assertion macros for the checker file.
`ifndef PULSE_PEAK_PEDESTAL_EXTRACTOR_ASSERT_SVH
`define PULSE_PEAK_PEDESTAL_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define PPE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define PPE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define PPE_ASSERT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ppe_pkg.sv */
`timescale 1ns / 1ps

package ppe_pkg;

   localparam int MAX_SAMPLES_DEFAULT = 64;
   localparam int SAMPLE_BITS_DEFAULT = 10;
   localparam int QUEUE_DEPTH         = 4;

   localparam int SAMPLE_FIELD_BITS = 10;
   localparam int WINDOW_MAX        = 16;
   localparam int BSUM_MAX          = 16383;
   localparam int BSQ_MAX           = 16777215;
   localparam int VAL_MAX           = 16383;
   localparam int VAL_MIN           = -16384;
   localparam logic [15:0] CNT_MAX  = 16'hFFFF;
   localparam logic [29:0] TOT_MAX  = 30'h3FFF_FFFF;
   localparam logic [44:0] SQT_MAX  = 45'h1FFF_FFFF_FFFF;

   localparam logic [5:0] PEDESTAL_FIRST_RESET   = 6'd0;
   localparam logic [4:0] PEDESTAL_COUNT_RESET   = 5'd5;
   localparam logic [5:0] EXPECTED_INDEX_RESET   = 6'd5;
   localparam logic [2:0] WINDOW_HALF_RESET      = 3'd2;
   localparam logic [9:0] SATURATION_LIMIT_RESET = 10'd1020;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef enum logic [2:0] {
      REG_PEDESTAL_FIRST   = 3'd0,
      REG_PEDESTAL_COUNT   = 3'd1,
      REG_EXPECTED_INDEX   = 3'd2,
      REG_WINDOW_HALF      = 3'd3,
      REG_SATURATION_LIMIT = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_ACCEPTED       = 2'd0,
      STATUS_SATURATED      = 2'd1,
      STATUS_BELOW_PEDESTAL = 2'd2,
      STATUS_REJECTED       = 2'd3
   } status_type;

   typedef struct packed {
      logic [5:0] pedestal_first;
      logic [4:0] pedestal_count;
      logic [5:0] expected_index;
      logic [2:0] window_half;
      logic [9:0] saturation_limit;
   } cfg_type;

   // One queued command: a finished event summary or a statistics clear.
   typedef struct packed {
      logic        clear;
      logic [5:0]  best_position;
      logic [9:0]  best_amplitude;
      logic [13:0] baseline_sum;
      logic [23:0] baseline_squares;
      logic [9:0]  expected_sample;
      logic [4:0]  window_samples;
      logic        expected_missing;
   } entry_type;

   localparam int RSP_DATA_BITS = 168;

endpackage

/* hw/rtl/ppe_queue.sv */
`timescale 1ns / 1ps

module ppe_queue #(
   parameter int DEPTH = ppe_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ppe_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                valid,
   output ppe_pkg::entry_type  pop_entry
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ppe_pkg::entry_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign valid     = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hw/rtl/ppe_front.sv */
`timescale 1ns / 1ps

module ppe_front #(
   parameter int MAX_SAMPLES = ppe_pkg::MAX_SAMPLES_DEFAULT,
   parameter int SAMPLE_BITS = ppe_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  ppe_pkg::cfg_type   cfg,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [15:0]        req_tdata,
   input  logic               req_tlast,
   input  logic               req_tuser,
   input  logic               q_full,
   output logic               q_push,
   output ppe_pkg::entry_type q_entry
);

   localparam int SW = (SAMPLE_BITS < ppe_pkg::SAMPLE_FIELD_BITS) ?
                       SAMPLE_BITS : ppe_pkg::SAMPLE_FIELD_BITS;
   localparam logic [9:0] SAMPLE_MASK = 10'((1 << SW) - 1);

   logic [5:0]  position_ff, position_in;
   logic        past_end_ff, past_end_in;
   logic [5:0]  best_pos_ff, best_pos_in;
   logic [9:0]  best_amp_ff, best_amp_in;
   logic [13:0] bsum_ff, bsum_in;
   logic [23:0] bsq_ff, bsq_in;
   logic [9:0]  captured_ff, captured_in;

   logic        accept, is_clear;
   logic [9:0]  s;
   logic [4:0]  win_len;
   logic [6:0]  wend, n_arrived, hi;
   logic        in_window;
   logic [14:0] bsum_wide;
   logic [19:0] s_square;
   logic [24:0] bsq_wide;
   logic [5:0]  upd_pos;
   logic [9:0]  upd_amp, upd_cap;
   logic [13:0] upd_bsum;
   logic [23:0] upd_bsq;
   logic [4:0]  n_win;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign is_clear   = (req_tuser == ppe_pkg::OP_CLEAR);
   assign s          = req_tdata[9:0] & SAMPLE_MASK;

   assign win_len   = (cfg.pedestal_count > 5'(ppe_pkg::WINDOW_MAX)) ?
                      5'(ppe_pkg::WINDOW_MAX) : cfg.pedestal_count;
   assign wend      = {1'b0, cfg.pedestal_first} + {2'b0, win_len};
   assign in_window = ({1'b0, position_ff} >= {1'b0, cfg.pedestal_first}) &&
                      ({1'b0, position_ff} < wend);
   assign bsum_wide = {1'b0, bsum_ff} + {5'b0, s};
   assign s_square  = s * s;
   assign bsq_wide  = {1'b0, bsq_ff} + {5'b0, s_square};

   // Window samples that actually arrived by the end of this event.
   assign n_arrived = past_end_ff ? 7'(MAX_SAMPLES) : {1'b0, position_ff} + 7'd1;
   assign hi        = (wend < n_arrived) ? wend : n_arrived;
   assign n_win     = (hi > {1'b0, cfg.pedestal_first}) ?
                      5'(hi - {1'b0, cfg.pedestal_first}) : 5'd0;

   always_comb begin
      upd_pos  = best_pos_ff;
      upd_amp  = best_amp_ff;
      upd_bsum = bsum_ff;
      upd_bsq  = bsq_ff;
      upd_cap  = captured_ff;
      if (!past_end_ff) begin
         if (position_ff == '0 || s > best_amp_ff) begin
            upd_amp = s;
            upd_pos = position_ff;
         end
         if (in_window) begin
            upd_bsum = (bsum_wide > 15'(ppe_pkg::BSUM_MAX)) ?
                       14'(ppe_pkg::BSUM_MAX) : bsum_wide[13:0];
            upd_bsq  = (bsq_wide > 25'(ppe_pkg::BSQ_MAX)) ?
                       24'(ppe_pkg::BSQ_MAX) : bsq_wide[23:0];
         end
         if (position_ff == cfg.expected_index) begin
            upd_cap = s;
         end
      end
   end

   always_comb begin
      position_in = position_ff;
      past_end_in = past_end_ff;
      best_pos_in = best_pos_ff;
      best_amp_in = best_amp_ff;
      bsum_in     = bsum_ff;
      bsq_in      = bsq_ff;
      captured_in = captured_ff;
      q_push      = 1'b0;

      q_entry                  = '0;
      q_entry.best_position    = upd_pos;
      q_entry.best_amplitude   = upd_amp;
      q_entry.baseline_sum     = upd_bsum;
      q_entry.baseline_squares = upd_bsq;
      q_entry.expected_sample  = upd_cap;
      q_entry.window_samples   = n_win;
      q_entry.expected_missing = ({1'b0, cfg.expected_index} >= n_arrived);

      if (accept && is_clear) begin
         q_push        = 1'b1;
         q_entry.clear = 1'b1;
      end else if (accept) begin
         if (req_tlast) begin
            // Hand the summary over and start a fresh event.
            q_push      = 1'b1;
            position_in = '0;
            past_end_in = 1'b0;
            best_pos_in = '0;
            best_amp_in = '0;
            bsum_in     = '0;
            bsq_in      = '0;
            captured_in = '0;
         end else begin
            best_pos_in = upd_pos;
            best_amp_in = upd_amp;
            bsum_in     = upd_bsum;
            bsq_in      = upd_bsq;
            captured_in = upd_cap;
            if (!past_end_ff) begin
               if (position_ff >= 6'(MAX_SAMPLES - 1)) begin
                  past_end_in = 1'b1;
               end else begin
                  position_in = position_ff + 6'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         past_end_ff <= 1'b0;
         best_pos_ff <= '0;
         best_amp_ff <= '0;
         bsum_ff     <= '0;
         bsq_ff      <= '0;
         captured_ff <= '0;
      end else begin
         position_ff <= position_in;
         past_end_ff <= past_end_in;
         best_pos_ff <= best_pos_in;
         best_amp_ff <= best_amp_in;
         bsum_ff     <= bsum_in;
         bsq_ff      <= bsq_in;
         captured_ff <= captured_in;
      end
   end

endmodule

/* hw/rtl/ppe_back.sv */
`timescale 1ns / 1ps

module ppe_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ppe_pkg::cfg_type                      cfg,
   input  logic                                  q_valid,
   input  ppe_pkg::entry_type                    q_entry,
   output logic                                  q_pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [ppe_pkg::RSP_DATA_BITS-1:0]     rsp_tdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_SQUARE,
      S_DELIVER
   } state_type;

   state_type                           state_ff;
   ppe_pkg::entry_type                  entry_ff;
   logic signed [14:0]                  val_ff;
   ppe_pkg::status_type                 status_ff;
   logic [27:0]                         sq_ff;
   logic [15:0]                         count_ff;
   logic [29:0]                         total_ff;
   logic [44:0]                         square_total_ff;
   logic                                rsp_tvalid_ff;
   logic [ppe_pkg::RSP_DATA_BITS-1:0]   rsp_tdata_ff;

   logic [14:0]         product;
   logic signed [15:0]  diff;
   logic signed [14:0]  val_in;
   logic [5:0]          peak_offset;
   ppe_pkg::status_type status_in;
   logic [15:0]         count_in;
   logic [30:0]         total_wide;
   logic [29:0]         total_in;
   logic [45:0]         square_wide;
   logic [44:0]         square_total_in;
   logic                out_free;
   logic                deliver;

   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign deliver    = (state_ff == S_DELIVER) && out_free;

   assign product = {10'b0, entry_ff.window_samples} * {5'b0, entry_ff.expected_sample};
   assign diff    = $signed({1'b0, product}) - $signed({2'b0, entry_ff.baseline_sum});
   assign peak_offset = (entry_ff.best_position > cfg.expected_index) ?
                        entry_ff.best_position - cfg.expected_index :
                        cfg.expected_index - entry_ff.best_position;

   always_comb begin
      if (diff > 16'(ppe_pkg::VAL_MAX)) begin
         val_in = 15'(ppe_pkg::VAL_MAX);
      end else if (diff < 16'(ppe_pkg::VAL_MIN)) begin
         val_in = 15'(ppe_pkg::VAL_MIN);
      end else begin
         val_in = diff[14:0];
      end
   end

   always_comb begin
      if (entry_ff.best_amplitude > cfg.saturation_limit) begin
         status_in = ppe_pkg::STATUS_SATURATED;
      end else if (val_in < 0) begin
         status_in = ppe_pkg::STATUS_BELOW_PEDESTAL;
      end else if (peak_offset > {3'b0, cfg.window_half} ||
                   entry_ff.expected_sample >= cfg.saturation_limit ||
                   entry_ff.expected_missing) begin
         status_in = ppe_pkg::STATUS_REJECTED;
      end else begin
         status_in = ppe_pkg::STATUS_ACCEPTED;
      end
   end

   // Saturating statistics update, applied only to accepted events.
   assign total_wide  = {1'b0, total_ff} + {17'b0, val_ff[13:0]};
   assign square_wide = {1'b0, square_total_ff} + {18'b0, sq_ff};

   always_comb begin
      count_in        = count_ff;
      total_in        = total_ff;
      square_total_in = square_total_ff;
      if (status_ff == ppe_pkg::STATUS_ACCEPTED) begin
         if (count_ff != ppe_pkg::CNT_MAX) begin
            count_in = count_ff + 16'd1;
         end
         total_in        = (total_wide > {1'b0, ppe_pkg::TOT_MAX}) ?
                           ppe_pkg::TOT_MAX : total_wide[29:0];
         square_total_in = (square_wide > {1'b0, ppe_pkg::SQT_MAX}) ?
                           ppe_pkg::SQT_MAX : square_wide[44:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_tvalid_ff   <= 1'b0;
         count_ff        <= '0;
         total_ff        <= '0;
         square_total_ff <= '0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && !deliver) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  if (q_entry.clear) begin
                     count_ff        <= '0;
                     total_ff        <= '0;
                     square_total_ff <= '0;
                  end else begin
                     entry_ff <= q_entry;
                     state_ff <= S_EVAL;
                  end
               end
            end
            S_EVAL: begin
               val_ff    <= val_in;
               status_ff <= status_in;
               state_ff  <= S_SQUARE;
            end
            S_SQUARE: begin
               sq_ff    <= val_ff[13:0] * val_ff[13:0];
               state_ff <= S_DELIVER;
            end
            S_DELIVER: begin
               // Hold until the output register can take the result.
               if (out_free) begin
                  count_ff        <= count_in;
                  total_ff        <= total_in;
                  square_total_ff <= square_total_in;
                  rsp_tvalid_ff   <= 1'b1;
                  rsp_tdata_ff    <= {6'b0, square_total_in, total_in, count_in,
                                      status_ff, val_ff,
                                      entry_ff.baseline_squares,
                                      entry_ff.baseline_sum,
                                      entry_ff.best_amplitude,
                                      entry_ff.best_position};
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* hw/rtl/pulse_peak_pedestal_extractor.sv */
`timescale 1ns / 1ps
// Pulse peak finder with pedestal subtraction.
// req_ channel: one ADC sample per transaction in req_tdata[9:0]; req_tuser is
// the op (0 sample, 1 clear statistics); req_tlast marks the last sample of the
// event. Samples are taken one per cycle while the four-entry command queue
// has room. A clear returns nothing and leaves the event in progress alone.
// rsp_ channel: one result per event, issued after its last sample has passed
// through the queue. The back end takes one event at a time (queue pop, signal and
// status, square, statistics and output register) and a clear only as a queue
// pop, so events with fewer samples than the back end has steps drain from the
// queue at the back end's pace and stall req_tready once it fills.
// csr_ channel: always ready; csr_index selects the register, csr_data holds
// the value. Write only while the block is idle.
// Reset (synchronous, active high) restores register defaults, empties the
// queue and zeroes the event state and statistics. While rsp_tready is low
// the result holds in the output register; one more event finishes into the
// back end and then the queue fills and req_tready drops.
module pulse_peak_pedestal_extractor #(
   parameter int MAX_SAMPLES = ppe_pkg::MAX_SAMPLES_DEFAULT,
   parameter int SAMPLE_BITS = ppe_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: sample[9:0], zero [15:10]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,
   input  logic                              req_tlast,
   // req_tuser: op[0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata: peak_position[5:0], peak_amplitude[15:6], baseline_sum[29:16],
   // baseline_square_sum[53:30], scaled_signal[68:54], event_status[70:69],
   // accepted_events[86:71], accepted_sum[116:87],
   // accepted_square_sum[161:117], zero [167:162]
   output logic [ppe_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [2:0]                        csr_index,
   input  logic [9:0]                        csr_data
);

   ppe_pkg::cfg_type   cfg_ff;
   logic               q_full, q_push, q_pop, q_valid;
   ppe_pkg::entry_type push_entry, pop_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pedestal_first   <= ppe_pkg::PEDESTAL_FIRST_RESET;
         cfg_ff.pedestal_count   <= ppe_pkg::PEDESTAL_COUNT_RESET;
         cfg_ff.expected_index   <= ppe_pkg::EXPECTED_INDEX_RESET;
         cfg_ff.window_half      <= ppe_pkg::WINDOW_HALF_RESET;
         cfg_ff.saturation_limit <= ppe_pkg::SATURATION_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            ppe_pkg::REG_PEDESTAL_FIRST:   cfg_ff.pedestal_first   <= csr_data[5:0];
            ppe_pkg::REG_PEDESTAL_COUNT:   cfg_ff.pedestal_count   <= csr_data[4:0];
            ppe_pkg::REG_EXPECTED_INDEX:   cfg_ff.expected_index   <= csr_data[5:0];
            ppe_pkg::REG_WINDOW_HALF:      cfg_ff.window_half      <= csr_data[2:0];
            ppe_pkg::REG_SATURATION_LIMIT: cfg_ff.saturation_limit <= csr_data;
            default: ;
         endcase
      end
   end

   ppe_front #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   ppe_queue #(
      .DEPTH (ppe_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .pop_entry  (pop_entry)
   );

   ppe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_entry    (pop_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* hw/rtl/ppe_checker.sv */
`timescale 1ns / 1ps
`include "pulse_peak_pedestal_extractor_assert.svh"

module ppe_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ppe_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   logic [1:0]  status;
   logic        val_negative;
   logic [15:0] accepted_events;

   assign status          = rsp_tdata[70:69];
   assign val_negative    = rsp_tdata[68];
   assign accepted_events = rsp_tdata[86:71];

   // Stalled result holds its payload.
   `PPE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // Below-pedestal status exactly when the peak is not saturated and the signal is negative.
   `PPE_ASSERT_NOW(a_below_sign, rsp_tvalid && status != ppe_pkg::STATUS_SATURATED, (status == ppe_pkg::STATUS_BELOW_PEDESTAL) == val_negative, "status disagrees with signal sign")

   // An accepted event is always counted.
   `PPE_ASSERT_NOW(a_accept_counted, rsp_tvalid && status == ppe_pkg::STATUS_ACCEPTED, accepted_events != 16'd0, "accepted event not counted")

   // Reset leaves no result pending.
   `PPE_ASSERT_ALWAYS(a_reset_idle, reset, !rsp_tvalid, "result valid after reset")

endmodule

bind pulse_peak_pedestal_extractor ppe_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* test/pulse_peak_pedestal_extractor_tb.sv */
`timescale 1ns / 1ps

module pulse_peak_pedestal_extractor_tb;
   import ppe_pkg::*;

   typedef int unsigned sample_list_type[$];

   class event_scoreboard_type;
      cfg_type                  cfg;
      int unsigned              sample_pos;
      int unsigned              best_pos;
      int unsigned              best_amp;
      int unsigned              base_sum;
      int unsigned              base_squares;
      int unsigned              expected_sample;
      bit                       past_end;
      int unsigned              accepted_count;
      longint unsigned          accepted_total;
      longint unsigned          accepted_squares;
      logic [RSP_DATA_BITS-1:0] pending_summaries[$];
      int                       mismatches;

      function new();
         cfg = '{PEDESTAL_FIRST_RESET, PEDESTAL_COUNT_RESET, EXPECTED_INDEX_RESET,
                 WINDOW_HALF_RESET, SATURATION_LIMIT_RESET};
         accepted_count = 0;
         accepted_total = 0;
         accepted_squares = 0;
         mismatches = 0;
         clear_event();
      endfunction

      function void clear_event();
         sample_pos = 0;
         best_pos = 0;
         best_amp = 0;
         base_sum = 0;
         base_squares = 0;
         expected_sample = 0;
         past_end = 1'b0;
      endfunction

      function void set_reg(reg_index_type idx, logic [9:0] value);
         case (idx)
            REG_PEDESTAL_FIRST:   cfg.pedestal_first = value[5:0];
            REG_PEDESTAL_COUNT:   cfg.pedestal_count = value[4:0];
            REG_EXPECTED_INDEX:   cfg.expected_index = value[5:0];
            REG_WINDOW_HALF:      cfg.window_half = value[2:0];
            REG_SATURATION_LIMIT: cfg.saturation_limit = value;
            default: ;
         endcase
      endfunction

      function void note_sample(logic op, logic [9:0] sample, logic last);
         int unsigned              idx, win, wend, n_arrived, hi, n_win, peak_offset, s;
         int                       signed_val;
         status_type               status;
         logic [RSP_DATA_BITS-1:0] word;
         if (op == OP_CLEAR) begin
            accepted_count = 0;
            accepted_total = 0;
            accepted_squares = 0;
            return;
         end
         s = sample;
         idx = sample_pos;
         win = (cfg.pedestal_count > WINDOW_MAX) ? WINDOW_MAX : cfg.pedestal_count;
         wend = cfg.pedestal_first + win;
         if (!past_end) begin
            if (idx == 0 || s > best_amp) begin
               best_amp = s;
               best_pos = idx;
            end
            if (idx >= cfg.pedestal_first && idx < wend) begin
               base_sum += s;
               if (base_sum > BSUM_MAX) base_sum = BSUM_MAX;
               base_squares += s * s;
               if (base_squares > BSQ_MAX) base_squares = BSQ_MAX;
            end
            if (idx == cfg.expected_index) expected_sample = s;
         end
         if (!last) begin
            if (!past_end) begin
               if (idx >= MAX_SAMPLES_DEFAULT - 1) past_end = 1'b1;
               else sample_pos = idx + 1;
            end
            return;
         end

         n_arrived = past_end ? MAX_SAMPLES_DEFAULT : idx + 1;
         hi = (wend < n_arrived) ? wend : n_arrived;
         n_win = (hi > cfg.pedestal_first) ? hi - cfg.pedestal_first : 0;
         signed_val = int'(n_win * expected_sample) - int'(base_sum);
         if (signed_val > VAL_MAX) signed_val = VAL_MAX;
         if (signed_val < VAL_MIN) signed_val = VAL_MIN;

         peak_offset = (best_pos > cfg.expected_index) ? best_pos - cfg.expected_index
                                                       : cfg.expected_index - best_pos;
         if (best_amp > cfg.saturation_limit) status = STATUS_SATURATED;
         else if (signed_val < 0) status = STATUS_BELOW_PEDESTAL;
         else if (peak_offset > cfg.window_half ||
                  expected_sample >= cfg.saturation_limit ||
                  cfg.expected_index >= n_arrived) status = STATUS_REJECTED;
         else status = STATUS_ACCEPTED;

         if (status == STATUS_ACCEPTED) begin
            if (accepted_count < CNT_MAX) accepted_count++;
            accepted_total += longint'(signed_val);
            if (accepted_total > TOT_MAX) accepted_total = TOT_MAX;
            accepted_squares += longint'(signed_val) * longint'(signed_val);
            if (accepted_squares > SQT_MAX) accepted_squares = SQT_MAX;
         end

         word = '0;
         word[5:0]     = best_pos[5:0];
         word[15:6]    = best_amp[9:0];
         word[29:16]   = base_sum[13:0];
         word[53:30]   = base_squares[23:0];
         word[68:54]   = signed_val[14:0];
         word[70:69]   = status;
         word[86:71]   = accepted_count[15:0];
         word[116:87]  = accepted_total[29:0];
         word[161:117] = accepted_squares[44:0];
         pending_summaries = {pending_summaries, word};
         clear_event();
      endfunction

      function void check_summary(logic [RSP_DATA_BITS-1:0] actual);
         logic [RSP_DATA_BITS-1:0] expected, mask, exp_f, act_f;
         int                       lsb, width;
         string                    name;
         if (pending_summaries.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with no pending event summary: %h", $realtime, actual);
            return;
         end
         expected = pending_summaries.pop_front();
         for (int f = 0; f < 9; f++) begin
            case (f)
               0: begin lsb = 0;   width = 6;  name = "peak_position";       end
               1: begin lsb = 6;   width = 10; name = "peak_amplitude";      end
               2: begin lsb = 16;  width = 14; name = "baseline_sum";        end
               3: begin lsb = 30;  width = 24; name = "baseline_square_sum"; end
               4: begin lsb = 54;  width = 15; name = "scaled_signal";       end
               5: begin lsb = 69;  width = 2;  name = "event_status";        end
               6: begin lsb = 71;  width = 16; name = "accepted_events";     end
               7: begin lsb = 87;  width = 30; name = "accepted_sum";        end
               default: begin lsb = 117; width = 45; name = "accepted_square_sum"; end
            endcase
            mask = ({{(RSP_DATA_BITS-1){1'b0}}, 1'b1} << width) - 1'b1;
            exp_f = (expected >> lsb) & mask;
            act_f = (actual >> lsb) & mask;
            if (exp_f !== act_f) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: %s mismatch: expected %0d, got %0d",
                           $realtime, name, exp_f, act_f);
            end
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         req_tuser = OP_SAMPLE;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = REG_PEDESTAL_FIRST;
   logic [9:0]   csr_data = '0;

   bit tx_gaps = 1'b1;
   bit rx_gaps = 1'b1;
   bit hold_off_request = 1'b0;

   event_scoreboard_type sb = new();

   always #10 clock = ~clock;

   pulse_peak_pedestal_extractor i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_summary(rsp_tdata);
   end

   // Result-side flow control; a long hold-off lets the command queue fill up.
   initial begin
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            for (int c = 0; c < 300; c++) @(posedge clock);
         end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin
      #4_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_item(logic op, logic [9:0] sample, logic last);
      if (tx_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, sample};
      req_tuser  <= op;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(op, sample, last);
   endtask

   task automatic play_event(sample_list_type samples);
      for (int i = 0; i < samples.size(); i++) begin
         // occasionally slip a statistics clear into the event
         if ($urandom_range(0, 39) == 0)
            send_item(OP_CLEAR, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
         send_item(OP_SAMPLE, 10'(samples[i]), i == samples.size() - 1);
      end
   endtask

   task automatic write_reg(reg_index_type idx, logic [9:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, value);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending_summaries.size() != 0) @(posedge clock);
      // let trailing clears and partial events settle in the back end
      repeat (16) @(posedge clock);
   endtask

   function automatic sample_list_type noise_event(int unsigned len);
      sample_list_type q;
      for (int i = 0; i < len; i++) q = {q, $urandom_range(0, 1023)};
      return q;
   endfunction

   function automatic sample_list_type pulse_event();
      sample_list_type q;
      int unsigned     win, reach, len, pedestal, amp, peak_at;
      int              offset, pos;
      win = (sb.cfg.pedestal_count > WINDOW_MAX) ? WINDOW_MAX : sb.cfg.pedestal_count;
      reach = sb.cfg.expected_index + 1;
      if (sb.cfg.pedestal_first + win > reach) reach = sb.cfg.pedestal_first + win;
      len = reach + $urandom_range(0, 4);
      if (len > MAX_SAMPLES_DEFAULT) len = MAX_SAMPLES_DEFAULT;
      offset = int'($urandom_range(0, 2 * sb.cfg.window_half + 2)) -
               int'(sb.cfg.window_half) - 1;
      pos = int'(sb.cfg.expected_index) + offset;
      if (pos < 0) pos = 0;
      if (pos > MAX_SAMPLES_DEFAULT - 1) pos = MAX_SAMPLES_DEFAULT - 1;
      peak_at = pos;
      pedestal = $urandom_range(0, 150);
      amp = ($urandom_range(0, 9) == 0) ? 1023 : $urandom_range(pedestal + 40, 1023);
      for (int i = 0; i < len; i++) begin
         if (i == peak_at) q = {q, amp};
         else if (i + 1 == peak_at || i == peak_at + 1) q = {q, (amp + pedestal) / 2};
         else q = {q, pedestal + $urandom_range(0, 15)};
      end
      return q;
   endfunction

   task automatic run_phase(int unsigned first, int unsigned count, int unsigned exp_idx,
                            int unsigned half, int unsigned limit, int unsigned target,
                            bit pressure);
      sample_list_type q;
      int unsigned     items, pick;
      write_reg(REG_PEDESTAL_FIRST, 10'(first));
      write_reg(REG_PEDESTAL_COUNT, 10'(count));
      write_reg(REG_EXPECTED_INDEX, 10'(exp_idx));
      write_reg(REG_WINDOW_HALF, 10'(half));
      write_reg(REG_SATURATION_LIMIT, 10'(limit));
      csr_valid <= 1'b0;
      // one long event per phase, which may run past the sample limit
      q = noise_event($urandom_range(60, 72));
      play_event(q);
      items = q.size();
      if (pressure) begin
         hold_off_request = 1'b1;
         repeat (40) begin
            q = noise_event($urandom_range(1, 2));
            play_event(q);
            items += q.size();
         end
      end
      while (items < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) q = pulse_event();
         else if (pick < 85) begin
            q = pulse_event();
            while (q.size() > 1 && $urandom_range(0, 1)) void'(q.pop_back());
         end else if ($urandom_range(0, 7) == 0) q = noise_event($urandom_range(1, 80));
         else q = noise_event($urandom_range(1, 8));
         play_event(q);
         items += q.size();
      end
      drain_results();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default settings: accepted, tie on saturated peak, single sample,
      // below pedestal, clear, expected sample at the limit
      play_event({10, 10, 10, 10, 10, 500, 40, 20});
      play_event({1023, 1023, 0});
      play_event({0});
      play_event({100, 100, 100, 100, 100, 50});
      send_item(OP_CLEAR, 10'h3FF, 1'b1);
      play_event({10, 10, 10, 10, 10, 1020});
      drain_results();

      run_phase(0, 16, 20, 7, 1023, 110, 1'b0);
      run_phase(63, 31, 63, 0, 0, 110, 1'b0);
      run_phase(10, 0, 15, 3, 1020, 110, 1'b1);
      run_phase(40, 17, 50, 1, 800, 110, 1'b0);
      repeat (2)
         run_phase($urandom_range(0, 40), $urandom_range(0, 31), $urandom_range(0, 40),
                   $urandom_range(0, 7), $urandom_range(900, 1023), 110, 1'b0);
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      run_phase($urandom_range(0, 40), $urandom_range(0, 31), $urandom_range(0, 40),
                $urandom_range(0, 7), $urandom_range(900, 1023), 110, 1'b0);

      if (sb.mismatches == 0 && sb.pending_summaries.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ppe_pkg.sv
hw/rtl/ppe_queue.sv
hw/rtl/ppe_front.sv
hw/rtl/ppe_back.sv
hw/rtl/pulse_peak_pedestal_extractor.sv
hw/rtl/ppe_checker.sv
test/pulse_peak_pedestal_extractor_tb.sv
